FILE: src/rgbblur_pkg.sv
// ---------------------------------------------------------------------------
// rgbblur_pkg
// shared constants and control types of the rgb565 row box blur
// ---------------------------------------------------------------------------
package rgbblur_pkg;

  // window and ring sizes
  localparam int unsigned MAX_RADIUS  = 16;
  localparam int unsigned HIST_DEPTH  = 2 * MAX_RADIUS + 2;
  localparam int unsigned MAX_RESULTS = MAX_RADIUS + 1;
  localparam int unsigned PTR_W       = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W       = $clog2(HIST_DEPTH + 1);
  localparam int unsigned K_W         = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RAD_W       = 5;
  localparam int unsigned COL_W       = 12;

  // pixel layout
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned RED_W   = 5;
  localparam int unsigned GREEN_W = 6;
  localparam int unsigned BLUE_W  = 5;
  localparam int unsigned RED_LSB   = 11;
  localparam int unsigned GREEN_LSB = 5;

  // channel sums hold up to HIST_DEPTH pixels
  localparam int unsigned RSUM_W = RED_W + CNT_W;
  localparam int unsigned GSUM_W = GREEN_W + CNT_W;
  localparam int unsigned BSUM_W = BLUE_W + CNT_W;

  // quotients stay below 2**QUO_W, one quotient bit per divide step
  localparam int unsigned QUO_W  = GREEN_W;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  // controller to datapath
  typedef struct packed {
    logic load;      // take the accepted pixel into the window
    logic sub;       // remove the oldest pixel from the sums
    logic div_init;  // start the three divisions
    logic div_step;  // one quotient bit
    logic emit;      // load the result register
    logic finish;    // end of request, clear row state on row end
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic do_emit;
    logic do_drop;
    logic out_free;
  } sts_t;

endpackage

FILE: src/rgbblur_ram.sv
// ---------------------------------------------------------------------------
// rgbblur_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module rgbblur_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rgbblur_dp.sv
// ---------------------------------------------------------------------------
// rgbblur_dp
// datapath: pixel ring, channel sums, column counters, divider, result reg
// ---------------------------------------------------------------------------
module rgbblur_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgbblur_pkg::RAD_W-1:0]       cfg_wdata_i,
  input  logic [rgbblur_pkg::PIX_W-1:0]       pixel_i,
  input  logic                                row_end_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [rgbblur_pkg::PIX_W-1:0]       out_pixel_o,
  output logic                                out_last_o,
  input  rgbblur_pkg::cmd_t                   cmd_i,
  output rgbblur_pkg::sts_t                   sts_o
);

  localparam int unsigned PtrW  = rgbblur_pkg::PTR_W;
  localparam int unsigned CntW  = rgbblur_pkg::CNT_W;
  localparam int unsigned ColW  = rgbblur_pkg::COL_W;
  localparam int unsigned RadW  = rgbblur_pkg::RAD_W;
  localparam int unsigned QuoW  = rgbblur_pkg::QUO_W;
  localparam int unsigned RSumW = rgbblur_pkg::RSUM_W;
  localparam int unsigned GSumW = rgbblur_pkg::GSUM_W;
  localparam int unsigned BSumW = rgbblur_pkg::BSUM_W;
  localparam int unsigned PixW  = rgbblur_pkg::PIX_W;
  localparam int unsigned RedW  = rgbblur_pkg::RED_W;
  localparam int unsigned GrnW  = rgbblur_pkg::GREEN_W;
  localparam int unsigned BluW  = rgbblur_pkg::BLUE_W;
  localparam int unsigned RedL  = rgbblur_pkg::RED_LSB;
  localparam int unsigned GrnL  = rgbblur_pkg::GREEN_LSB;
  localparam int unsigned Depth = rgbblur_pkg::HIST_DEPTH;
  localparam int unsigned IdxW  = PtrW + 1;

  // configuration and row state
  logic [RadW-1:0]  radius_q;
  logic [RadW-1:0]  rr_q, rr_d;
  logic             row_end_q;
  logic [PtrW-1:0]  wp_q, wp_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [ColW-1:0]  in_col_q, in_col_d;
  logic [ColW-1:0]  out_col_q, out_col_d;
  logic [RSumW-1:0] rsum_q, rsum_d;
  logic [GSumW-1:0] gsum_q, gsum_d;
  logic [BSumW-1:0] bsum_q, bsum_d;
  logic [rgbblur_pkg::K_W-1:0] k_q, k_d;

  // divider
  logic [CntW-1:0]  dvs_q;
  logic [CntW-1:0]  rrem_q, grem_q, brem_q;
  logic [QuoW-1:0]  rnum_q, gnum_q, bnum_q;

  // result register
  logic             ovalid_q;
  logic [PixW-1:0]  opix_q;
  logic             olast_q;

  logic [PixW-1:0]  old_pix;
  logic [PtrW-1:0]  rd_idx;
  logic [IdxW-1:0]  idx_raw;
  logic [ColW-1:0]  pending;
  logic [ColW-1:0]  rr_ext;
  logic [ColW-1:0]  cnt_ext;
  logic             row_start;
  logic             last_now;

  rgbblur_ram #(
    .WIDTH (PixW),
    .DEPTH (Depth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (wp_q),
    .wdata_i (pixel_i),
    .raddr_i (rd_idx),
    .rdata_o (old_pix)
  );

  // window bookkeeping
  assign pending   = in_col_q - out_col_q;
  assign rr_ext    = ColW'(rr_q);
  assign cnt_ext   = ColW'(count_q);
  assign row_start = (in_col_q == '0) && (out_col_q == '0) && (count_q == '0);
  assign last_now  = row_end_q && (pending == ColW'(1));

  // oldest pixel sits count places behind the write pointer
  assign idx_raw = IdxW'(wp_q) + IdxW'(Depth) - IdxW'(count_q);
  assign rd_idx  = (idx_raw >= IdxW'(Depth)) ? PtrW'(idx_raw - IdxW'(Depth))
                                             : PtrW'(idx_raw);

  always_comb begin
    sts_o.do_emit = ((k_q == '0) && (pending > rr_ext)) ||
                    (row_end_q && (pending != '0) &&
                     (k_q < rgbblur_pkg::K_W'(rgbblur_pkg::MAX_RESULTS)));
    sts_o.do_drop = (cnt_ext > pending) && ((cnt_ext - pending) > rr_ext);
    sts_o.out_free = !ovalid_q || out_ready_i;
  end

  always_comb begin
    rr_d      = rr_q;
    wp_d      = wp_q;
    count_d   = count_q;
    in_col_d  = in_col_q;
    out_col_d = out_col_q;
    rsum_d    = rsum_q;
    gsum_d    = gsum_q;
    bsum_d    = bsum_q;
    k_d       = k_q;
    if (cmd_i.load) begin
      if (row_start) begin
        rr_d = (radius_q > RadW'(rgbblur_pkg::MAX_RADIUS)) ?
               RadW'(rgbblur_pkg::MAX_RADIUS) : radius_q;
      end
      wp_d     = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + PtrW'(1);
      count_d  = count_q + CntW'(1);
      in_col_d = in_col_q + ColW'(1);
      rsum_d   = rsum_q + RSumW'(pixel_i[RedL +: RedW]);
      gsum_d   = gsum_q + GSumW'(pixel_i[GrnL +: GrnW]);
      bsum_d   = bsum_q + BSumW'(pixel_i[0 +: BluW]);
      k_d      = '0;
    end
    if (cmd_i.sub) begin
      count_d = count_q - CntW'(1);
      rsum_d  = rsum_q - RSumW'(old_pix[RedL +: RedW]);
      gsum_d  = gsum_q - GSumW'(old_pix[GrnL +: GrnW]);
      bsum_d  = bsum_q - BSumW'(old_pix[0 +: BluW]);
    end
    if (cmd_i.emit) begin
      out_col_d = out_col_q + ColW'(1);
      k_d       = k_q + rgbblur_pkg::K_W'(1);
    end
    if (cmd_i.finish && row_end_q) begin
      count_d   = '0;
      in_col_d  = '0;
      out_col_d = '0;
      rsum_d    = '0;
      gsum_d    = '0;
      bsum_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RadW'(1);
      rr_q      <= RadW'(1);
      row_end_q <= 1'b0;
      wp_q      <= '0;
      count_q   <= '0;
      in_col_q  <= '0;
      out_col_q <= '0;
      rsum_q    <= '0;
      gsum_q    <= '0;
      bsum_q    <= '0;
      k_q       <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        row_end_q <= row_end_i;
      end
      rr_q      <= rr_d;
      wp_q      <= wp_d;
      count_q   <= count_d;
      in_col_q  <= in_col_d;
      out_col_q <= out_col_d;
      rsum_q    <= rsum_d;
      gsum_q    <= gsum_d;
      bsum_q    <= bsum_d;
      k_q       <= k_d;
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // restoring division, sum >> QuoW is already below the divisor
  function automatic logic [CntW+QuoW-1:0] div_bit(
    input logic [CntW-1:0] rem,
    input logic [QuoW-1:0] num,
    input logic [CntW-1:0] dvs
  );
    logic [CntW:0] trial;
    trial = {rem, num[QuoW-1]};
    if (trial >= {1'b0, dvs}) begin
      div_bit = {CntW'(trial - {1'b0, dvs}), {num[QuoW-2:0], 1'b1}};
    end else begin
      div_bit = {CntW'(trial), {num[QuoW-2:0], 1'b0}};
    end
  endfunction

  logic [CntW+QuoW-1:0] rstep, gstep, bstep;
  assign rstep = div_bit(rrem_q, rnum_q, dvs_q);
  assign gstep = div_bit(grem_q, gnum_q, dvs_q);
  assign bstep = div_bit(brem_q, bnum_q, dvs_q);

  // num shifts out the dividend bits and takes in quotient bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvs_q  <= count_q;
      rrem_q <= CntW'(rsum_q >> QuoW);
      grem_q <= CntW'(gsum_q >> QuoW);
      brem_q <= CntW'(bsum_q >> QuoW);
      rnum_q <= rsum_q[QuoW-1:0];
      gnum_q <= gsum_q[QuoW-1:0];
      bnum_q <= bsum_q[QuoW-1:0];
    end else if (cmd_i.div_step) begin
      {rrem_q, rnum_q} <= rstep;
      {grem_q, gnum_q} <= gstep;
      {brem_q, bnum_q} <= bstep;
    end
    if (cmd_i.emit) begin
      olast_q <= last_now;
      if (dvs_q == '0) begin
        opix_q <= '0;
      end else begin
        opix_q <= {rnum_q[RedW-1:0], gnum_q[GrnW-1:0], bnum_q[BluW-1:0]};
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_pixel_o = opix_q;
  assign out_last_o  = olast_q;

  // window never holds more pixels than the ring
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("window count beyond ring depth");

  // a result is only loaded when the result register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!ovalid_q || out_ready_i))
    else $error("result register overwritten");

  // a division never starts on an empty window
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> count_q != '0)
    else $error("division by empty window");

  // quotients fit their channel fields, num holds them after the last step
  a_quo_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (rnum_q[QuoW-1] == 1'b0) && (bnum_q[QuoW-1] == 1'b0))
    else $error("channel average overflow");

endmodule

FILE: src/rgbblur_ctrl.sv
// ---------------------------------------------------------------------------
// rgbblur_ctrl
// sequencer: per request load, then one emit loop pass per result
// ---------------------------------------------------------------------------
module rgbblur_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rgbblur_pkg::sts_t sts_i,
  output rgbblur_pkg::cmd_t cmd_o
);

  localparam int unsigned StW   = 3;
  localparam int unsigned StepW = rgbblur_pkg::STEP_W;

  localparam logic [StW-1:0] ST_IDLE  = 3'd0;
  localparam logic [StW-1:0] ST_CHECK = 3'd1;
  localparam logic [StW-1:0] ST_SUB   = 3'd2;
  localparam logic [StW-1:0] ST_INIT  = 3'd3;
  localparam logic [StW-1:0] ST_DIV   = 3'd4;
  localparam logic [StW-1:0] ST_OUT   = 3'd5;

  logic [StW-1:0]   state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.do_emit) begin
          if (sts_i.do_drop) begin
            // ring read address is live here, data arrives in ST_SUB
            state_d = ST_SUB;
          end else begin
            state_d = ST_INIT;
          end
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + StepW'(1);
        if (step_q == StepW'(rgbblur_pkg::DIV_STEPS - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // an accepted request is always examined next
  a_load_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_CHECK)
    else $error("load not followed by check");

  // a result follows the full divide sequence
  a_emit_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == StepW'(rgbblur_pkg::DIV_STEPS - 1))
      |=> state_q == ST_OUT)
    else $error("divide sequence cut short");

endmodule

FILE: src/rgb565_running_box_blur_row.sv
// ---------------------------------------------------------------------------
// rgb565_running_box_blur_row
// horizontal running box blur over one row of rgb565 pixels
// ---------------------------------------------------------------------------
// sequence: a request is loaded, then checked; each result adds a drop of
//   the oldest pixel when it leaves the window, divide init, the 6 divide
//   steps and an output that waits until the result register is free
// one request at a time; the restoring divider loop is shared by all three channels
// a row end request flushes up to radius+1 results (radius clamped to MAX_RADIUS) back to back
// reset: async active low, radius 1, empty window, ring undefined until written
module rgb565_running_box_blur_row (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: radius, taken from the first pixel of the next row
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // pixel requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pixel_in
  input  logic        s_axis_tlast,   // row_end_in
  // blurred pixels
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] pixel_out
  output logic        m_axis_tlast    // row_end_out
);

  rgbblur_pkg::cmd_t cmd;
  rgbblur_pkg::sts_t sts;

  // sequencer: load, check, optional drop, divide, emit
  rgbblur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // window state, ring memory, divider and result register
  rgbblur_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pixel_i     (s_axis_tdata),
    .row_end_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
